// ----- hdl/assert_macros.svh -----
// Assertion macros used by dnnm_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/dnnm_pkg.sv -----
package dnnm_pkg;

    localparam int unsigned TIDX_W = 10;
    localparam int unsigned BIN_W  = 6;
    localparam int unsigned VAL_W  = 16;
    localparam int unsigned SRC_W  = 16;
    localparam int unsigned DIST_W = 38;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIDX_W-1:0] target_index;
        logic [BIN_W-1:0]  bin_index;
        logic [VAL_W-1:0]  bin_value;
        logic [SRC_W-1:0]  source_index;
    } t_in_item;

    typedef struct packed {
        logic [SRC_W-1:0]  query_index;
        logic [TIDX_W-1:0] best_target;
        logic [DIST_W-1:0] best_distance;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_run;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic start_req;
        logic scan_last;
        logic pipe_empty;
        logic out_full;
    } t_status;

endpackage

// ----- hdl/dnnm_ctrl.sv -----
module dnnm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dnnm_pkg::t_status  i_status,
    output dnnm_pkg::t_cmd     o_cmd,
    output logic               o_in_stall
);
    import dnnm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.start_req) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.pipe_empty) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- hdl/dnnm_dp.sv -----
module dnnm_dp #(
    parameter int unsigned MAX_TARGETS = 1024,
    parameter int unsigned BINS        = 33,
    parameter int unsigned VALUE_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dnnm_pkg::t_in_item  i_in,
    input  dnnm_pkg::t_cmd      i_cmd,
    input  logic                i_out_stall,
    output dnnm_pkg::t_status   o_status,
    output logic                o_out_valid,
    output dnnm_pkg::t_out_item o_out
);
    import dnnm_pkg::*;

    localparam int unsigned DEPTH = MAX_TARGETS * BINS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned SW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int unsigned CW    = $clog2(MAX_TARGETS + 1);
    localparam int unsigned KW    = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int unsigned PW    = 2 * VALUE_BITS;

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] r_qbin [BINS];

    logic [CW-1:0] r_count;
    logic [SW-1:0] r_slot;
    logic [KW-1:0] r_bin;
    logic [AW-1:0] r_addr;

    // stage valids: s1 = read data, s2 = diff, s3 = square
    logic          r_v1, r_v2, r_v3;
    logic          r_e1, r_e2, r_e3;
    logic [SW-1:0] r_s1, r_s2, r_s3;
    logic [VALUE_BITS-1:0] r_rd, r_qa, r_d;
    logic [PW-1:0] r_sq;

    logic [DIST_W-1:0] r_acc, r_best_d;
    logic [SW-1:0]     r_best_t;
    logic              r_have;
    logic [SRC_W-1:0]  r_src;

    logic r_out_valid;
    t_out_item r_out;

    logic load_ok, query_ok, wrap;
    logic [AW-1:0] waddr;
    logic [DIST_W-1:0] sum;

    assign load_ok = i_cmd.accept && i_in.op == OP_LOAD
        && {22'd0, i_in.target_index} < 32'(MAX_TARGETS)
        && {26'd0, i_in.bin_index} < 32'(BINS);
    assign query_ok = i_in.op == OP_QUERY && {26'd0, i_in.bin_index} < 32'(BINS);
    assign waddr = AW'(32'(i_in.target_index) * BINS + 32'(i_in.bin_index));
    assign wrap = {26'd0, r_bin} == 32'(BINS - 1);

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            mem[waddr] <= i_in.bin_value[VALUE_BITS-1:0];
        end
        r_rd <= mem[r_addr];
        r_qa <= r_qbin[r_bin];
        if (i_cmd.accept && query_ok) begin
            r_qbin[i_in.bin_index[KW-1:0]] <= i_in.bin_value[VALUE_BITS-1:0];
        end
        if (i_cmd.scan_start) begin
            r_src <= i_in.source_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && i_in.op == OP_CLEAR) begin
            r_count <= '0;
        end else if (load_ok && 32'(i_in.target_index) + 1 > 32'(r_count)) begin
            r_count <= CW'(32'(i_in.target_index) + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_bin  <= '0;
            r_addr <= '0;
        end else if (i_cmd.scan_start) begin
            r_slot <= '0;
            r_bin  <= '0;
            r_addr <= '0;
        end else if (i_cmd.scan_run) begin
            r_addr <= r_addr + 1'b1;
            if (wrap) begin
                r_bin  <= '0;
                r_slot <= r_slot + 1'b1;
            end else begin
                r_bin <= r_bin + 1'b1;
            end
        end
    end

    assign o_status.start_req = query_ok && {26'd0, i_in.bin_index} == 32'(BINS - 1)
        && r_count != '0;
    assign o_status.scan_last = wrap && 32'(r_slot) + 1 == 32'(r_count);
    assign o_status.pipe_empty = !r_v1 && !r_v2 && !r_v3;
    assign o_status.out_full = r_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_run;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_e1 <= wrap;
        r_s1 <= r_slot;
        r_e2 <= r_e1;
        r_s2 <= r_s1;
        r_d  <= (r_qa >= r_rd) ? r_qa - r_rd : r_rd - r_qa;
        r_e3 <= r_e2;
        r_s3 <= r_s2;
        r_sq <= r_d * r_d;
    end

    assign sum = r_acc + DIST_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_acc  <= '0;
        end else if (i_cmd.scan_start) begin
            r_have <= 1'b0;
            r_acc  <= '0;
        end else if (r_v3) begin
            if (r_e3) begin
                r_acc <= '0;
                if (!r_have || sum < r_best_d) begin
                    r_best_d <= sum;
                    r_best_t <= r_s3;
                end
                r_have <= 1'b1;
            end else begin
                r_acc <= sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.query_index   <= r_src;
            r_out.best_target   <= TIDX_W'(r_best_t);
            r_out.best_distance <= r_best_d;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule

// ----- hdl/descriptor_nearest_neighbor_match.sv -----
// Loads, clears and non-final query bins: one transfer per cycle while idle.
// Final query bin (with targets loaded): scan of N*BINS bins (one bin read per cycle
// from the target memory port), pipeline drain and result load; no input taken meanwhile.
// Result held in an output register; the next item is taken while it waits.
// Synchronous active-low reset clears control and target count; memories keep data.
module descriptor_nearest_neighbor_match #(
    parameter int unsigned MAX_TARGETS = 1024,
    parameter int unsigned BINS        = 33,
    parameter int unsigned VALUE_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dnnm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dnnm_pkg::t_out_item o_out_data
);
    import dnnm_pkg::*;

    t_cmd    cmd;
    t_status status;

    dnnm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dnnm_dp #(
        .MAX_TARGETS (MAX_TARGETS),
        .BINS        (BINS),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

// ----- hdl/dnnm_checker.sv -----
`include "assert_macros.svh"

module dnnm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input dnnm_pkg::t_out_item o_out_data
);
    import dnnm_pkg::*;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    `ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !o_in_stall && !i_in_valid, !o_in_stall)
    `ASSERT_IMPL(a_no_out_in_reset, i_clk, 1'b1, !$past(i_rst_n), !o_out_valid)

endmodule

bind descriptor_nearest_neighbor_match dnnm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- tb/descriptor_nearest_neighbor_match_tb.sv -----
`timescale 1ns / 100ps

module descriptor_nearest_neighbor_match_tb;
    import dnnm_pkg::*;

    localparam int unsigned NTGT = 1024;
    localparam int unsigned NBIN = 33;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    descriptor_nearest_neighbor_match uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    logic [VAL_W-1:0] tgt_bins [NTGT][NBIN];
    logic [VAL_W-1:0] qry_bins [NBIN];
    int unsigned      tgt_count;

    t_in_item  pending_items [$];
    t_out_item match_queue [$];
    int        errors;
    int        n_items;
    int        n_matches;
    bit        calm;
    bit        hold_off;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic void predict_match(t_in_item it);
        logic [DIST_W-1:0] best_d, d;
        logic [VAL_W:0]    df;
        int unsigned       best_j;
        if (it.op == OP_CLEAR) begin
            tgt_count = 0;
        end else if (it.op == OP_LOAD) begin
            if (it.bin_index < NBIN) begin
                tgt_bins[it.target_index][it.bin_index] = it.bin_value;
                if (it.target_index + 1 > tgt_count) tgt_count = it.target_index + 1;
            end
        end else if (it.op == OP_QUERY && it.bin_index < NBIN) begin
            qry_bins[it.bin_index] = it.bin_value;
            if (it.bin_index == NBIN - 1 && tgt_count != 0) begin
                best_j = 0;
                for (int j = 0; j < tgt_count; j++) begin
                    d = '0;
                    for (int k = 0; k < NBIN; k++) begin
                        df = (qry_bins[k] >= tgt_bins[j][k]) ? qry_bins[k] - tgt_bins[j][k]
                                                             : tgt_bins[j][k] - qry_bins[k];
                        d += DIST_W'(df) * DIST_W'(df);
                    end
                    if (j == 0 || d < best_d) begin
                        best_d = d;
                        best_j = j;
                    end
                end
                match_queue.push_back('{it.source_index, best_j[TIDX_W-1:0], best_d});
            end
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_match(i_in_data);
                void'(pending_items.pop_front());
                n_items++;
            end
            if (i_in_valid && o_in_stall) begin
                i_in_valid <= 1'b1;
            end else if (pending_items.size() > 0
                         && !hold_off && (calm || $urandom_range(99) >= 11)) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_items[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_m;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (match_queue.size() == 0) begin
                    $error("unexpected match %p", o_out_data);
                    errors++;
                end else begin
                    exp_m = match_queue.pop_front();
                    n_matches++;
                    if (o_out_data.query_index !== exp_m.query_index) begin
                        $error("query_index exp %0d got %0d", exp_m.query_index,
                               o_out_data.query_index);
                        errors++;
                    end
                    if (o_out_data.best_target !== exp_m.best_target) begin
                        $error("best_target exp %0d got %0d", exp_m.best_target,
                               o_out_data.best_target);
                        errors++;
                    end
                    if (o_out_data.best_distance !== exp_m.best_distance) begin
                        $error("best_distance exp %0d got %0d", exp_m.best_distance,
                               o_out_data.best_distance);
                        errors++;
                    end
                end
            end
            i_out_stall <= !calm && ($urandom_range(99) < 11);
        end
    end

    function automatic t_in_item mk(logic [1:0] op, int unsigned t, int unsigned b,
                                    int unsigned v, int unsigned s);
        t_in_item it;
        it.op = op;
        it.target_index = TIDX_W'(t);
        it.bin_index = BIN_W'(b);
        it.bin_value = VAL_W'(v);
        it.source_index = SRC_W'(s);
        return it;
    endfunction

    task automatic add_target(int unsigned t, int unsigned vmax);
        for (int k = 0; k < NBIN; k++)
            pending_items.push_back(mk(OP_LOAD, t, k, $urandom_range(vmax), $urandom));
    endtask

    task automatic add_query(int unsigned vmax, bit full);
        int unsigned s;
        s = $urandom_range(65535);
        for (int k = full ? 0 : NBIN - 1 - $urandom_range(4); k < NBIN; k++)
            pending_items.push_back(mk(OP_QUERY, $urandom, k, $urandom_range(vmax), s));
    endtask

    task automatic wait_drain();
        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (match_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // fresh contiguous set 0..n-1 keeps all scanned slots written
    task automatic new_set(int unsigned n, int unsigned vmax);
        pending_items.push_back(mk(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
        for (int t = 0; t < n; t++) add_target(t, vmax);
    endtask

    initial begin
        int unsigned n, vmax;
        errors = 0;
        n_items = 0;
        n_matches = 0;
        calm = 1'b0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        tgt_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: query on empty set, extremes, tie, ignored items
        add_query(65535, 1'b1);
        pending_items.push_back(mk(OP_LOAD, 0, 40, 65535, 0));
        pending_items.push_back(mk(OP_UNUSED, 1023, 63, 65535, 65535));
        for (int k = 0; k < NBIN; k++) pending_items.push_back(mk(OP_LOAD, 0, k, 65535, 0));
        for (int k = 0; k < NBIN; k++) pending_items.push_back(mk(OP_LOAD, 1, k, 0, 0));
        for (int k = 0; k < NBIN; k++) pending_items.push_back(mk(OP_QUERY, 0, k, 0, 65535));
        for (int k = 0; k < NBIN; k++) pending_items.push_back(mk(OP_QUERY, 0, k, 65535, 0));
        pending_items.push_back(mk(OP_QUERY, 0, 63, 5, 1));
        wait_drain();
        new_set(2, 0);
        add_query(0, 1'b1);
        wait_drain();

        for (int ph = 0; ph < 6; ph++) begin
            calm = (ph == 2);
            n = (ph == 4) ? 6 : $urandom_range(1, 4);
            vmax = (ph % 3 == 0) ? 65535 : $urandom_range(3, 300);
            new_set(n, vmax);
            for (int q = 0; q < 6; q++) begin
                add_query((q % 2) ? vmax : 65535, q < 3);
                if ($urandom_range(3) == 0) begin
                    pending_items.push_back(mk(OP_QUERY, $urandom, $urandom_range(33, 63),
                                               $urandom, $urandom));
                    pending_items.push_back(mk(OP_LOAD, $urandom_range(n - 1),
                                               $urandom_range(33, 63), $urandom, $urandom));
                end
                if ($urandom_range(4) == 0) add_target($urandom_range(n - 1), vmax);
            end
            if (ph == 5) begin
                while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
                hold_off = 1'b1;
                while (match_queue.size() != 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end
        wait_drain();
        $display("%0d items, %0d matches checked over extreme and random target sets",
                 n_items, n_matches);
        if (errors == 0) begin
            $display("descriptor_nearest_neighbor_match_tb passed");
        end else begin
            $display("descriptor_nearest_neighbor_match_tb failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("descriptor_nearest_neighbor_match_tb failed");
        $finish;
    end

endmodule
